[sv/eorp_pkg.sv]
// ----------------------------------------------------------------------------
// eorp_pkg
// Shared types and constants for the EDNS(0) OPT record parser.
// ----------------------------------------------------------------------------
package eorp_pkg;

    localparam int unsigned MaxOptions    = 16;
    localparam int unsigned MaxOptionData = 256;
    localparam int unsigned QueueDepth    = 4;
    localparam int unsigned QueueAw       = 2;

    localparam logic [7:0]  RootLabel = 8'h00;
    localparam logic [15:0] OptType   = 16'd41;

    typedef enum logic [2:0] {
        K_HEADER = 3'd0,
        K_OPT    = 3'd1,
        K_DATA   = 3'd2,
        K_DONE   = 3'd3,
        K_ERROR  = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        E_NAME    = 3'd0,
        E_TYPE    = 3'd1,
        E_TRUNC   = 3'd2,
        E_OVERRUN = 3'd3,
        E_TOOLONG = 3'd4,
        E_TOOMANY = 3'd5
    } t_err;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] payload_size;
        logic [7:0]  ext_resp_code;
        logic [7:0]  edns_version;
        logic        dnssec_ok;
        logic [14:0] z_bits;
        logic [15:0] option_code;
        logic [8:0]  option_length;
        logic [7:0]  data_byte;
        logic [4:0]  options_seen;
        t_err        error_code;
        logic [16:0] bytes_consumed;
    } t_result;

    // Classified beat: up to two results.
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_entry;

endpackage

[sv/eorp_front.sv]
// ----------------------------------------------------------------------------
// eorp_front
// Parses record bytes and classifies each beat into zero to two results.
// ----------------------------------------------------------------------------
module eorp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_end_of_record,
    output logic            o_push,
    output eorp_pkg::t_entry o_entry
);

    typedef enum logic [1:0] {
        PH_NAME, PH_HEADER, PH_OPTIONS, PH_SKIP
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_hidx, n_hidx;
    logic [63:0] r_hsh, n_hsh;
    logic [15:0] r_rrem, n_rrem;
    logic [1:0]  r_oidx, n_oidx;
    logic [31:0] r_osh, n_osh;
    logic [8:0]  r_odrem, n_odrem;
    logic [4:0]  r_ocnt, n_ocnt;
    logic [16:0] r_cons, n_cons;

    eorp_pkg::t_entry ent;
    logic [63:0] sh;
    logic [31:0] osh;
    logic [15:0] rrem_m1;
    logic [15:0] len;

    function automatic eorp_pkg::t_result f_zero(input eorp_pkg::t_kind k);
        eorp_pkg::t_result r;
        r = '0;
        r.kind = k;
        return r;
    endfunction

    always_comb begin
        n_phase = r_phase;
        n_hidx  = r_hidx;
        n_hsh   = r_hsh;
        n_rrem  = r_rrem;
        n_oidx  = r_oidx;
        n_osh   = r_osh;
        n_odrem = r_odrem;
        n_ocnt  = r_ocnt;
        n_cons  = r_cons;
        ent     = '0;
        sh      = {r_hsh[55:0], i_rx_byte};
        osh     = {r_osh[23:0], i_rx_byte};
        rrem_m1 = r_rrem - 16'd1;
        len     = osh[15:0];
        case (r_phase)
            PH_NAME: begin
                n_cons = 17'd1;
                if (i_rx_byte != eorp_pkg::RootLabel) begin
                    ent.v0 = 1'b1;
                    ent.r0 = f_zero(eorp_pkg::K_ERROR);
                    ent.r0.error_code = eorp_pkg::E_NAME;
                    n_phase = PH_SKIP;
                end else begin
                    n_phase = PH_HEADER;
                    n_hidx  = '0;
                    n_hsh   = '0;
                end
            end
            PH_HEADER: begin
                n_cons = r_cons + 17'd1;
                n_hsh  = sh;
                n_hidx = r_hidx + 4'd1;
                if (r_hidx == 4'd1 && sh[15:0] != eorp_pkg::OptType) begin
                    ent.v0 = 1'b1;
                    ent.r0 = f_zero(eorp_pkg::K_ERROR);
                    ent.r0.error_code = eorp_pkg::E_TYPE;
                    n_phase = PH_SKIP;
                end else if (r_hidx == 4'd9) begin
                    ent.v0 = 1'b1;
                    ent.r0 = f_zero(eorp_pkg::K_HEADER);
                    ent.r0.payload_size  = sh[63:48];
                    ent.r0.ext_resp_code = sh[47:40];
                    ent.r0.edns_version  = sh[39:32];
                    ent.r0.dnssec_ok     = sh[31];
                    ent.r0.z_bits        = sh[30:16];
                    n_rrem  = sh[15:0];
                    n_phase = PH_OPTIONS;
                    n_oidx  = '0;
                    n_osh   = '0;
                    n_odrem = '0;
                    n_ocnt  = '0;
                    if (sh[15:0] == 16'd0) begin
                        ent.v1 = 1'b1;
                        ent.r1 = f_zero(eorp_pkg::K_DONE);
                        ent.r1.bytes_consumed = r_cons + 17'd1;
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_OPTIONS: begin
                n_cons = r_cons + 17'd1;
                if (r_odrem != 9'd0) begin
                    ent.v0 = 1'b1;
                    ent.r0 = f_zero(eorp_pkg::K_DATA);
                    ent.r0.option_code   = r_osh[31:16];
                    ent.r0.option_length = r_osh[8:0];
                    ent.r0.data_byte     = i_rx_byte;
                    n_odrem = r_odrem - 9'd1;
                    n_rrem  = rrem_m1;
                    if (rrem_m1 == 16'd0) begin
                        ent.v1 = 1'b1;
                        ent.r1 = f_zero(eorp_pkg::K_DONE);
                        ent.r1.options_seen   = r_ocnt;
                        ent.r1.bytes_consumed = r_cons + 17'd1;
                        n_phase = PH_SKIP;
                    end
                end else if (r_oidx == 2'd0 && r_ocnt >= 5'(eorp_pkg::MaxOptions)) begin
                    ent.v0 = 1'b1;
                    ent.r0 = f_zero(eorp_pkg::K_ERROR);
                    ent.r0.error_code = eorp_pkg::E_TOOMANY;
                    n_phase = PH_SKIP;
                end else if (r_oidx == 2'd0 && r_rrem < 16'd4) begin
                    ent.v0 = 1'b1;
                    ent.r0 = f_zero(eorp_pkg::K_ERROR);
                    ent.r0.error_code = eorp_pkg::E_OVERRUN;
                    n_phase = PH_SKIP;
                end else begin
                    n_osh  = osh;
                    n_oidx = r_oidx + 2'd1;
                    n_rrem = rrem_m1;
                    if (r_oidx == 2'd3) begin
                        if (len > rrem_m1) begin
                            ent.v0 = 1'b1;
                            ent.r0 = f_zero(eorp_pkg::K_ERROR);
                            ent.r0.error_code = eorp_pkg::E_OVERRUN;
                            n_phase = PH_SKIP;
                        end else if (len > 16'(eorp_pkg::MaxOptionData)) begin
                            ent.v0 = 1'b1;
                            ent.r0 = f_zero(eorp_pkg::K_ERROR);
                            ent.r0.error_code = eorp_pkg::E_TOOLONG;
                            n_phase = PH_SKIP;
                        end else begin
                            ent.v0 = 1'b1;
                            ent.r0 = f_zero(eorp_pkg::K_OPT);
                            ent.r0.option_code   = osh[31:16];
                            ent.r0.option_length = osh[8:0];
                            n_ocnt  = r_ocnt + 5'd1;
                            n_odrem = len[8:0];
                            if (len == 16'd0 && rrem_m1 == 16'd0) begin
                                ent.v1 = 1'b1;
                                ent.r1 = f_zero(eorp_pkg::K_DONE);
                                ent.r1.options_seen   = r_ocnt + 5'd1;
                                ent.r1.bytes_consumed = r_cons + 17'd1;
                                n_phase = PH_SKIP;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        if (i_end_of_record) begin
            if (n_phase == PH_HEADER || n_phase == PH_OPTIONS) begin
                if (ent.v0) begin
                    ent.v1 = 1'b1;
                    ent.r1 = f_zero(eorp_pkg::K_ERROR);
                    ent.r1.error_code = eorp_pkg::E_TRUNC;
                end else begin
                    ent.v0 = 1'b1;
                    ent.r0 = f_zero(eorp_pkg::K_ERROR);
                    ent.r0.error_code = eorp_pkg::E_TRUNC;
                end
            end
            n_phase = PH_NAME;
            n_hidx  = '0;
            n_hsh   = '0;
            n_rrem  = '0;
            n_oidx  = '0;
            n_osh   = '0;
            n_odrem = '0;
            n_ocnt  = '0;
            n_cons  = '0;
        end
    end

    assign o_push  = i_valid && (ent.v0 || ent.v1);
    assign o_entry = ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NAME;
            r_hidx  <= '0;
            r_hsh   <= '0;
            r_rrem  <= '0;
            r_oidx  <= '0;
            r_osh   <= '0;
            r_odrem <= '0;
            r_ocnt  <= '0;
            r_cons  <= '0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_hidx  <= n_hidx;
            r_hsh   <= n_hsh;
            r_rrem  <= n_rrem;
            r_oidx  <= n_oidx;
            r_osh   <= n_osh;
            r_odrem <= n_odrem;
            r_ocnt  <= n_ocnt;
            r_cons  <= n_cons;
        end
    end

`ifndef SYNTHESIS
    a_v1_needs_v0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ent.v1 |-> ent.v0) else $error("second result without first");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= 5'(eorp_pkg::MaxOptions)) else $error("option count overflow");
    a_eor_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_end_of_record) |=> (r_phase == PH_NAME && r_cons == 17'd0))
        else $error("no re-arm after last byte");
`endif

endmodule

[sv/eorp_back.sv]
// ----------------------------------------------------------------------------
// eorp_back
// Queues classified beats and drains their results one per output beat.
// ----------------------------------------------------------------------------
module eorp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  eorp_pkg::t_entry i_entry,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_stall,
    output eorp_pkg::t_result o_result
);

    eorp_pkg::t_entry r_mem [eorp_pkg::QueueDepth];
    logic [eorp_pkg::QueueAw:0]   r_cnt, n_cnt;
    logic [eorp_pkg::QueueAw-1:0] r_wp, r_rp;
    logic                         r_sub;
    eorp_pkg::t_entry             head;
    logic                         pop, take;

    assign head     = r_mem[r_rp];
    assign o_valid  = (r_cnt != '0);
    assign o_result = (r_sub || !head.v0) ? head.r1 : head.r0;
    assign take     = o_valid && !i_stall;
    assign pop      = take && (r_sub || !head.v1 || !head.v0);
    assign o_full   = (r_cnt >= (eorp_pkg::QueueAw+1)'(eorp_pkg::QueueDepth - 1));
    assign n_cnt    = r_cnt + (eorp_pkg::QueueAw+1)'(i_push) - (eorp_pkg::QueueAw+1)'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= '0;
            r_rp  <= '0;
            r_sub <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp  <= r_rp + 1'b1;
                r_sub <= 1'b0;
            end else if (take) begin
                r_sub <= 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (eorp_pkg::QueueAw+1)'(eorp_pkg::QueueDepth))
        else $error("queue overflow");
    a_sub_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> o_valid) else $error("second half without entry");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("stalled beat dropped");
`endif

endmodule

[sv/edns_opt_record_parser_unit.sv]
// ----------------------------------------------------------------------------
// edns_opt_record_parser_unit
// EDNS(0) OPT record parser: byte stream in, header/option/done/error out.
// ----------------------------------------------------------------------------
// One record byte is taken per cycle while the queue is not full; each byte
// yields zero, one or two results that pass through a four-entry queue, which
// holds up to three beats, and leave one per cycle unless the output is
// stalled. A byte that yields two results presents them one after the other;
// input is stalled whenever the queue holds three beats.
module edns_opt_record_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_end_of_record,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [15:0] o_payload_size,
    output logic [7:0]  o_ext_resp_code,
    output logic [7:0]  o_edns_version,
    output logic        o_dnssec_ok,
    output logic [14:0] o_z_bits,
    output logic [15:0] o_option_code,
    output logic [8:0]  o_option_length,
    output logic [7:0]  o_data_byte,
    output logic [4:0]  o_options_seen,
    output logic [2:0]  o_error_code,
    output logic [16:0] o_bytes_consumed
);

    logic              full, acc, push;
    eorp_pkg::t_entry  entry;
    eorp_pkg::t_result res;

    assign o_stall = full;
    assign acc     = i_valid && !full;

    eorp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (acc),
        .i_rx_byte      (i_rx_byte),
        .i_end_of_record(i_end_of_record),
        .o_push         (push),
        .o_entry        (entry)
    );

    eorp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_full  (full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_result(res)
    );

    assign o_kind           = res.kind;
    assign o_payload_size   = res.payload_size;
    assign o_ext_resp_code  = res.ext_resp_code;
    assign o_edns_version   = res.edns_version;
    assign o_dnssec_ok      = res.dnssec_ok;
    assign o_z_bits         = res.z_bits;
    assign o_option_code    = res.option_code;
    assign o_option_length  = res.option_length;
    assign o_data_byte      = res.data_byte;
    assign o_options_seen   = res.options_seen;
    assign o_error_code     = res.error_code;
    assign o_bytes_consumed = res.bytes_consumed;

endmodule

[test/eorp_checker.sv]
// ----------------------------------------------------------------------------
// eorp_checker
// Watches both channels of the OPT record parser, predicts every result from
// the accepted bytes and compares each result beat field by field.
// ----------------------------------------------------------------------------
module eorp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_end_of_record,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_kind,
    input  logic [15:0] i_payload_size,
    input  logic [7:0]  i_ext_resp_code,
    input  logic [7:0]  i_edns_version,
    input  logic        i_dnssec_ok,
    input  logic [14:0] i_z_bits,
    input  logic [15:0] i_option_code,
    input  logic [8:0]  i_option_length,
    input  logic [7:0]  i_data_byte,
    input  logic [4:0]  i_options_seen,
    input  logic [2:0]  i_error_code,
    input  logic [16:0] i_bytes_consumed,
    output int          o_failures,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        PH_NAME, PH_HEADER, PH_OPTIONS, PH_SKIP
    } t_phase;

    t_phase      phase;
    logic [3:0]  hdr_idx;
    logic [63:0] hdr_sr;
    logic [15:0] rdata_left;
    logic [1:0]  opt_idx;
    logic [31:0] opt_sr;
    logic [8:0]  data_left;
    logic [4:0]  opt_cnt;
    logic [16:0] consumed;

    eorp_pkg::t_result expected_results[$];

    function automatic eorp_pkg::t_result blank(eorp_pkg::t_kind k);
        eorp_pkg::t_result r;
        r = '0;
        r.kind = k;
        r.error_code = eorp_pkg::E_NAME;
        return r;
    endfunction

    task automatic clear_parser();
        phase = PH_NAME;
        hdr_idx = '0;
        hdr_sr = '0;
        rdata_left = '0;
        opt_idx = '0;
        opt_sr = '0;
        data_left = '0;
        opt_cnt = '0;
        consumed = '0;
    endtask

    task automatic push_error(eorp_pkg::t_err e);
        eorp_pkg::t_result r;
        r = blank(eorp_pkg::K_ERROR);
        r.error_code = e;
        expected_results.push_back(r);
        phase = PH_SKIP;
    endtask

    task automatic push_done();
        eorp_pkg::t_result r;
        r = blank(eorp_pkg::K_DONE);
        r.options_seen = opt_cnt;
        r.bytes_consumed = consumed;
        expected_results.push_back(r);
        phase = PH_SKIP;
    endtask

    task automatic push_option(eorp_pkg::t_kind k, logic [7:0] b);
        eorp_pkg::t_result r;
        r = blank(k);
        r.option_code = opt_sr[31:16];
        r.option_length = opt_sr[8:0];
        if (k == eorp_pkg::K_DATA) r.data_byte = b;
        expected_results.push_back(r);
    endtask

    task automatic parse_option_byte(logic [7:0] b);
        logic [15:0] len;
        if (data_left > 0) begin
            push_option(eorp_pkg::K_DATA, b);
            data_left--;
            rdata_left--;
            if (rdata_left == 0) push_done();
            return;
        end
        if (opt_idx == 0) begin
            if (opt_cnt >= eorp_pkg::MaxOptions) begin
                push_error(eorp_pkg::E_TOOMANY);
                return;
            end
            if (rdata_left < 4) begin
                push_error(eorp_pkg::E_OVERRUN);
                return;
            end
        end
        opt_sr = {opt_sr[23:0], b};
        opt_idx++;
        rdata_left--;
        if (opt_idx != 0) return;
        len = opt_sr[15:0];
        if (len > rdata_left) begin
            push_error(eorp_pkg::E_OVERRUN);
            return;
        end
        if (len > eorp_pkg::MaxOptionData) begin
            push_error(eorp_pkg::E_TOOLONG);
            return;
        end
        push_option(eorp_pkg::K_OPT, 8'h00);
        opt_cnt++;
        data_left = len[8:0];
        if (len == 0 && rdata_left == 0) push_done();
    endtask

    task automatic parse_byte(logic [7:0] b, logic last);
        eorp_pkg::t_result r;
        case (phase)
            PH_NAME: begin
                consumed = 1;
                if (b != eorp_pkg::RootLabel) begin
                    push_error(eorp_pkg::E_NAME);
                end else begin
                    phase = PH_HEADER;
                    hdr_idx = '0;
                    hdr_sr = '0;
                end
            end
            PH_HEADER: begin
                consumed++;
                hdr_sr = {hdr_sr[55:0], b};
                hdr_idx++;
                if (hdr_idx == 2 && hdr_sr[15:0] != eorp_pkg::OptType) begin
                    push_error(eorp_pkg::E_TYPE);
                end else if (hdr_idx >= 10) begin
                    r = blank(eorp_pkg::K_HEADER);
                    r.payload_size = hdr_sr[63:48];
                    r.ext_resp_code = hdr_sr[47:40];
                    r.edns_version = hdr_sr[39:32];
                    r.dnssec_ok = hdr_sr[31];
                    r.z_bits = hdr_sr[30:16];
                    expected_results.push_back(r);
                    rdata_left = hdr_sr[15:0];
                    phase = PH_OPTIONS;
                    opt_idx = '0;
                    opt_sr = '0;
                    data_left = '0;
                    opt_cnt = '0;
                    if (rdata_left == 0) push_done();
                end
            end
            PH_OPTIONS: begin
                consumed++;
                parse_option_byte(b);
            end
            default: ;
        endcase
        if (last) begin
            if (phase == PH_HEADER || phase == PH_OPTIONS) push_error(eorp_pkg::E_TRUNC);
            clear_parser();
        end
    endtask

    task automatic compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            o_failures++;
        end
    endtask

    always @(posedge i_clk) begin
        eorp_pkg::t_result e;
        if (!i_rst_n) begin
            clear_parser();
        end else begin
            if (i_valid && !i_stall_in) parse_byte(i_rx_byte, i_end_of_record);
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result beat, kind %0d", i_kind);
                    o_failures++;
                end else begin
                    e = expected_results.pop_front();
                    compare_field("kind", e.kind, i_kind);
                    compare_field("payload_size", e.payload_size, i_payload_size);
                    compare_field("ext_resp_code", e.ext_resp_code, i_ext_resp_code);
                    compare_field("edns_version", e.edns_version, i_edns_version);
                    compare_field("dnssec_ok", e.dnssec_ok, i_dnssec_ok);
                    compare_field("z_bits", e.z_bits, i_z_bits);
                    compare_field("option_code", e.option_code, i_option_code);
                    compare_field("option_length", e.option_length, i_option_length);
                    compare_field("data_byte", e.data_byte, i_data_byte);
                    compare_field("options_seen", e.options_seen, i_options_seen);
                    compare_field("error_code", e.error_code, i_error_code);
                    compare_field("bytes_consumed", e.bytes_consumed, i_bytes_consumed);
                end
            end
        end
        o_pending = expected_results.size();
    end
endmodule

[test/tb_edns_opt_record_parser_unit.sv]
// ----------------------------------------------------------------------------
// tb_edns_opt_record_parser_unit
// Feeds directed and random OPT records, mostly well formed with random
// content plus corrupted and truncated ones, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_edns_opt_record_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        end_of_record;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [15:0] payload_size;
    logic [7:0]  ext_resp_code;
    logic [7:0]  edns_version;
    logic        dnssec_ok;
    logic [14:0] z_bits;
    logic [15:0] option_code;
    logic [8:0]  option_length;
    logic [7:0]  data_byte;
    logic [4:0]  options_seen;
    logic [2:0]  error_code;
    logic [16:0] bytes_consumed;
    int          failures;
    int          pending;
    int          bytes_sent;
    bit          long_hold;
    bit          sink_free;

    logic [8:0] rec_bytes[$];

    edns_opt_record_parser_unit dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_rx_byte(rx_byte), .i_end_of_record(end_of_record),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_kind(kind), .o_payload_size(payload_size), .o_ext_resp_code(ext_resp_code),
        .o_edns_version(edns_version), .o_dnssec_ok(dnssec_ok), .o_z_bits(z_bits),
        .o_option_code(option_code), .o_option_length(option_length),
        .o_data_byte(data_byte), .o_options_seen(options_seen),
        .o_error_code(error_code), .o_bytes_consumed(bytes_consumed)
    );

    eorp_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_stall_in(in_stall),
        .i_rx_byte(rx_byte), .i_end_of_record(end_of_record),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_kind(kind), .i_payload_size(payload_size), .i_ext_resp_code(ext_resp_code),
        .i_edns_version(edns_version), .i_dnssec_ok(dnssec_ok), .i_z_bits(z_bits),
        .i_option_code(option_code), .i_option_length(option_length),
        .i_data_byte(data_byte), .i_options_seen(options_seen),
        .i_error_code(error_code), .i_bytes_consumed(bytes_consumed),
        .o_failures(failures), .o_pending(pending)
    );

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_byte(logic [7:0] b);
        rec_bytes.push_back({1'b0, b});
    endtask

    task automatic add_word(logic [15:0] w);
        add_byte(w[15:8]);
        add_byte(w[7:0]);
    endtask

    // Build a record: nopt options, each of random length within limits.
    // corrupt: 0 none, 1 name, 2 type, 3 random byte, 4 oversize length
    task automatic build_record(int nopt, int maxlen, int corrupt);
        logic [8:0] lens[$];
        int total;
        int L;
        int pos;
        total = 0;
        for (int k = 0; k < nopt; k++) begin
            L = $urandom_range(0, maxlen);
            lens.push_back(L[8:0]);
            total += 4 + L;
        end
        add_byte(corrupt == 1 ? 8'($urandom_range(1, 255)) : eorp_pkg::RootLabel);
        add_word(corrupt == 2 ? 16'($urandom) : eorp_pkg::OptType);
        add_word(16'($urandom));
        add_word(16'($urandom));
        add_word(16'($urandom));
        add_word(16'(total));
        for (int k = 0; k < nopt; k++) begin
            add_word(16'($urandom));
            if (corrupt == 4 && k == nopt - 1) add_word(16'($urandom_range(257, 65535)));
            else add_word({7'd0, lens[k]});
            for (int j = 0; j < lens[k]; j++) add_byte(8'($urandom));
        end
        if (corrupt == 3) begin
            pos = $urandom_range(0, rec_bytes.size() - 1);
            rec_bytes[pos][7:0] = 8'($urandom);
        end
    endtask

    task automatic finish_record(int extra, bit cut);
        if (cut && rec_bytes.size() > 1)
            rec_bytes = rec_bytes[0:$urandom_range(0, rec_bytes.size() - 2)];
        for (int k = 0; k < extra; k++) add_byte(8'($urandom));
        rec_bytes[rec_bytes.size() - 1][8] = 1'b1;
    endtask

    task automatic send_queue();
        int g;
        while (rec_bytes.size() > 0) begin
            g = gap_len();
            if (g > 0) begin
                in_valid <= 1'b0;
                repeat (g) @(posedge clk);
            end
            in_valid <= 1'b1;
            {end_of_record, rx_byte} <= rec_bytes.pop_front();
            @(posedge clk);
            while (in_stall) @(posedge clk);
            bytes_sent++;
        end
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (long_hold) out_stall <= 1'b1;
        else if (sink_free) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(0, 99) < 30);
    end

    initial begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int shape;
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = '0;
        end_of_record = 1'b0;
        long_hold = 1'b0;
        sink_free = 1'b0;
        bytes_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: bad name, bad type, empty rdata with max field values, two options
        add_byte(8'hFF);
        add_byte(8'h00);
        finish_record(0, 0);
        add_byte(eorp_pkg::RootLabel); add_word(16'h0000);
        finish_record(0, 0);
        add_byte(eorp_pkg::RootLabel); add_word(eorp_pkg::OptType);
        add_word(16'hFFFF); add_word(16'hFFFF); add_word(16'hFFFF); add_word(16'h0000);
        finish_record(2, 0);
        add_byte(eorp_pkg::RootLabel); add_word(eorp_pkg::OptType);
        add_word(16'h0000); add_word(16'h0000); add_word(16'h0000); add_word(16'd11);
        add_word(16'hFFFF); add_word(16'd3); add_byte(8'hFF); add_byte(8'h00); add_byte(8'hA5);
        add_word(16'h0000); add_word(16'h0000);
        finish_record(0, 0);
        // short option header, then overrun, then too long
        add_byte(eorp_pkg::RootLabel); add_word(eorp_pkg::OptType);
        add_word(16'd0); add_word(16'd0); add_word(16'd0);
        add_word(16'd2); add_byte(8'd1); add_byte(8'd2);
        finish_record(0, 0);
        add_byte(eorp_pkg::RootLabel); add_word(eorp_pkg::OptType);
        add_word(16'd0); add_word(16'd0); add_word(16'd0);
        add_word(16'd8); add_word(16'd5); add_word(16'd9);
        finish_record(3, 0);
        add_byte(eorp_pkg::RootLabel); add_word(eorp_pkg::OptType);
        add_word(16'd0); add_word(16'd0); add_word(16'd0);
        add_word(16'd1000); add_word(16'd7); add_word(16'd257);
        finish_record(0, 0);
        send_queue();

        // too many options, the maximum option count, and a maximum-length option
        build_record(17, 1, 0);
        finish_record(0, 0);
        build_record(16, 0, 0);
        finish_record(0, 0);
        add_byte(eorp_pkg::RootLabel); add_word(eorp_pkg::OptType);
        add_word(16'd0); add_word(16'd0); add_word(16'd0);
        add_word(16'd260); add_word(16'h1234); add_word(16'd256);
        for (int k = 0; k < 256; k++) add_byte(8'($urandom));
        finish_record(0, 0);
        send_queue();
        drain();

        // receiver holds off while the sender keeps offering bytes
        long_hold = 1'b1;
        build_record(6, 4, 0);
        finish_record(0, 0);
        fork
            send_queue();
            begin
                repeat (200) @(posedge clk);
                long_hold = 1'b0;
            end
        join
        drain();

        sink_free = 1'b1;
        build_record(3, 6, 0);
        finish_record(0, 1);
        send_queue();
        sink_free = 1'b0;

        while (bytes_sent < 1800) begin
            shape = $urandom_range(0, 99);
            if (shape < 65) begin
                build_record($urandom_range(0, 4), ($urandom_range(0, 9) == 0) ? 40 : 6, 0);
                finish_record($urandom_range(0, 9) == 0 ? 2 : 0, 0);
            end else if (shape < 80) begin
                build_record($urandom_range(1, 4), 6, 0);
                finish_record(0, 1);
            end else if (shape < 95) begin
                build_record($urandom_range(1, 3), 6, $urandom_range(1, 4));
                finish_record(0, 0);
            end else begin
                for (int k = 0; k < $urandom_range(1, 12); k++) add_byte(8'($urandom));
                finish_record(0, 0);
            end
            send_queue();
            if ($urandom_range(0, 19) == 0) drain();
        end

        drain();
        repeat (20) @(posedge clk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
